// ===== sv/heading_pid_turn_controller_unit_macros.svh =====
// Assertion macros for the heading turn controller.
// Each expects clk and rst_n in scope; no other dependencies.
`ifndef HEADING_PID_TURN_CONTROLLER_UNIT_MACROS_SVH
`define HEADING_PID_TURN_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset only
`define HPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hpt_pkg.sv =====
// Shared types and constants for the heading turn controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package hpt_pkg;

  // Angle scale: headings and errors carry this many fraction bits
  localparam int ANG_FRAC = 4;

  // Field and register widths
  localparam int HEAD_W     = 13;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int BRAKE_W    = 9;
  localparam int MS_W       = 16;
  localparam int ERR_W      = 13;
  localparam int DERR_W     = 14;
  localparam int ESUM_W     = 18;
  localparam int DRIVE_W    = 16;
  localparam int REASON_W   = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_USER_W = 3;

  // Shared multiply-accumulate unit
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 32;
  localparam int ACC_W     = MUL_A_W + MUL_B_W;
  localparam int BRK_SPLIT = 24;

  // Angle thresholds in scaled units
  localparam int DEG_1   = 1 << ANG_FRAC;
  localparam int DEG_15  = 15 << ANG_FRAC;
  localparam int DEG_20  = 20 << ANG_FRAC;
  localparam int DEG_180 = 180 << ANG_FRAC;
  localparam int DEG_360 = 360 << ANG_FRAC;

  // Limits
  localparam int ESUM_LIMIT  = 3000 << ANG_FRAC;
  localparam int DRIVE_LIMIT = 25600;

  // Output scaling shifts
  localparam int SHIFT_PLAIN = 8 + ANG_FRAC;
  localparam int SHIFT_BRAKE = SHIFT_PLAIN + 8;

  // floor(g*7/10) as (g * 7 * ceil(2^30/10)) >> 30
  localparam int CUT_SHIFT = 30;
  localparam int CUT_MULT  = 7 * ((1 << CUT_SHIFT) / 10 + 1);

  // Result reason codes
  typedef enum logic [REASON_W-1:0] {
    RSN_RUN     = 2'd0,
    RSN_SETTLED = 2'd1,
    RSN_TIMEOUT = 2'd2
  } reason_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TARGET  = 3'd0,
    CFG_PGAIN   = 3'd1,
    CFG_IGAIN   = 3'd2,
    CFG_DGAIN   = 3'd3,
    CFG_BRAKE   = 3'd4,
    CFG_TIMEOUT = 3'd5,
    CFG_SETTLE  = 3'd6
  } cfg_addr_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CUT_MUL,
    ST_CUT_WR,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_BRK_LO,
    ST_BRK_HI,
    ST_FIN,
    ST_OUT
  } hpt_state_t;

  // Operand selection for the shared unit
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CUT,
    OP_PROP,
    OP_INTEG,
    OP_DERIV,
    OP_BRK_LO,
    OP_BRK_HI
  } op_sel_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic    in_ready;
    logic    eval;
    logic    mac_en;
    logic    mac_clr;
    logic    mac_sh_hi;
    op_sel_t op_sel;
    logic    cut_wr;
    logic    esum_wr;
    logic    brk_save;
    logic    fin;
    logic    out_valid;
  } ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic idle_hit;
    logic tmo_hit;
    logic cut_hit;
    logic brake_hit;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/hpt_mac.sv =====
// Shared signed multiply-accumulate unit of the heading turn controller.
// Depends on hpt_pkg for operand and accumulator widths.
`default_nettype none

module hpt_mac (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic                               clr,
  input  wire logic                               sh_hi,
  input  wire logic signed [hpt_pkg::MUL_A_W-1:0] op_a,
  input  wire logic signed [hpt_pkg::MUL_B_W-1:0] op_b,
  output logic signed      [hpt_pkg::ACC_W-1:0]   acc
);
  import hpt_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  // Form the product, optionally weighted by the upper split position
  always_comb begin
    prod    = op_a * op_b;
    addend  = sh_hi ? (prod <<< BRK_SPLIT) : prod;
    acc_nxt = (clr ? '0 : acc_r) + addend;
  end

  // Accumulate when enabled
  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== sv/hpt_ctrl.sv =====
// Sequencer of the heading turn controller: steps one item through the
// shared multiply-accumulate unit. Depends on hpt_pkg.
`default_nettype none

module hpt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             out_ready,
  input  wire hpt_pkg::status_t sts,
  output hpt_pkg::ctrl_t        ctl
);
  import hpt_pkg::*;

  hpt_state_t state_r;
  hpt_state_t state_nxt;

  // Hold or advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.idle_hit || sts.tmo_hit) state_nxt = ST_OUT;
        else if (sts.cut_hit)            state_nxt = ST_CUT_MUL;
        else                             state_nxt = ST_PROP;
      end
      ST_CUT_MUL: state_nxt = ST_CUT_WR;
      ST_CUT_WR:  state_nxt = ST_PROP;
      ST_PROP:    state_nxt = ST_INTEG;
      ST_INTEG:   state_nxt = ST_DERIV;
      ST_DERIV: begin
        state_nxt = sts.brake_hit ? ST_BRK_LO : ST_FIN;
      end
      ST_BRK_LO:  state_nxt = ST_BRK_HI;
      ST_BRK_HI:  state_nxt = ST_FIN;
      ST_FIN:     state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_EVAL: ctl.eval = 1'b1;
      ST_CUT_MUL: begin
        ctl.mac_en  = 1'b1;
        ctl.mac_clr = 1'b1;
        ctl.op_sel  = OP_CUT;
      end
      ST_CUT_WR: ctl.cut_wr = 1'b1;
      ST_PROP: begin
        ctl.mac_en  = 1'b1;
        ctl.mac_clr = 1'b1;
        ctl.op_sel  = OP_PROP;
        ctl.esum_wr = 1'b1;
      end
      ST_INTEG: begin
        ctl.mac_en = 1'b1;
        ctl.op_sel = OP_INTEG;
      end
      ST_DERIV: begin
        ctl.mac_en = 1'b1;
        ctl.op_sel = OP_DERIV;
      end
      ST_BRK_LO: begin
        ctl.mac_en   = 1'b1;
        ctl.mac_clr  = 1'b1;
        ctl.op_sel   = OP_BRK_LO;
        ctl.brk_save = 1'b1;
      end
      ST_BRK_HI: begin
        ctl.mac_en    = 1'b1;
        ctl.mac_sh_hi = 1'b1;
        ctl.op_sel    = OP_BRK_HI;
      end
      ST_FIN: ctl.fin = 1'b1;
      ST_OUT: ctl.out_valid = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/heading_pid_turn_controller_unit.sv =====
// Top level of the heading turn controller: ports, registers, PID datapath.
// Depends on hpt_pkg, hpt_mac, hpt_ctrl and the assertion macro header.
//
//   channel | direction | tdata (low bit up)          | tuser (low bit up)
//   in_     | sink      | heading[12:0], time_ms[44:13] | req_type
//   out_    | source    | drive_pct[15:0]             | done_res, done_reason[2:1]
//   cfg_    | sink      | cfg_addr selects, cfg_wdata carries the value
//
// One item at a time: evaluation, proportional, integral and derivative steps
// and a final step, plus a gain cut on the first sample near target and brake
// steps when the brake scale applies; idle or timed-out samples skip to output.
// The steps are serial on the single multiply-accumulate unit, one product a cycle.
// A result waits in the output register until taken; no item is accepted then.
// Reset is synchronous; the block starts idle and reports done until a start.
`default_nettype none

`include "heading_pid_turn_controller_unit_macros.svh"

module heading_pid_turn_controller_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: heading[12:0], time_ms[44:13], zero fill
  input  wire logic [hpt_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: req_type
  input  wire logic                                in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: drive_pct[15:0]
  output logic [hpt_pkg::DRIVE_W-1:0]              out_tdata,
  // out_tuser: done_res[0], done_reason[2:1]
  output logic [hpt_pkg::OUT_USER_W-1:0]           out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_we,
  input  wire logic [hpt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [hpt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import hpt_pkg::*;

  localparam logic signed [ERR_W:0]    E_180  = (ERR_W+1)'(DEG_180);
  localparam logic signed [ERR_W:0]    E_360  = (ERR_W+1)'(DEG_360);
  localparam logic        [ERR_W:0]    A_1    = (ERR_W+1)'(DEG_1);
  localparam logic        [ERR_W:0]    A_15   = (ERR_W+1)'(DEG_15);
  localparam logic        [ERR_W:0]    A_20   = (ERR_W+1)'(DEG_20);
  localparam logic signed [ESUM_W:0]   S_MAX  = (ESUM_W+1)'(ESUM_LIMIT);
  localparam logic signed [DRIVE_W-1:0] D_MAX = DRIVE_W'(DRIVE_LIMIT);

  // Configuration registers
  logic [HEAD_W-1:0]  target_r;
  logic [GAIN_W-1:0]  pgain_r;
  logic [GAIN_W-1:0]  igain_r;
  logic [GAIN_W-1:0]  dgain_r;
  logic [BRAKE_W-1:0] brake_r;
  logic [MS_W-1:0]    tmo_r;
  logic [MS_W-1:0]    settle_r;

  // Turn state
  logic signed [ESUM_W-1:0] esum_r;
  logic signed [ESUM_W-1:0] esum_nxt;
  logic signed [ERR_W-1:0]  last_err_r;
  logic [GAIN_W-1:0]        active_r;
  logic                     gain_cut_r;
  logic [TIME_W-1:0]        turn_start_r;
  logic [TIME_W-1:0]        win_start_r;
  logic                     finished_r;
  reason_t                  end_reason_r;

  // Item registers
  logic [HEAD_W-1:0]        head_r;
  logic [TIME_W-1:0]        time_r;
  logic signed [ERR_W-1:0]  e_r;
  logic                     near1_r;
  logic                     near15_r;
  logic                     near20_r;
  logic signed [MUL_B_W-1:0] brk_hi_r;

  // Output registers
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_done_r;
  reason_t                   out_reason_r;

  // Sequencer links
  ctrl_t   ctl;
  status_t sts;
  logic    in_acc;
  logic    start;

  // Datapath nets
  logic signed [ERR_W:0]     diff_w;
  logic signed [ERR_W:0]     e_w;
  logic [ERR_W:0]            ae_w;
  logic [TIME_W-1:0]         elapsed_w;
  logic [TIME_W-1:0]         settle_el_w;
  logic signed [ESUM_W:0]    esum_sum;
  logic signed [DERR_W-1:0]  de_w;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]          mag_w;
  logic [ACC_W-1:0]          shr_w;
  logic [DRIVE_W-1:0]        lim_w;
  logic signed [DRIVE_W-1:0] drive_w;
  logic                      settled_w;

  assign in_acc = in_tvalid && ctl.in_ready;
  assign start  = in_acc && in_tuser;

  // Wrap the error once into about +-180 degrees and take its size
  always_comb begin
    diff_w = $signed({1'b0, target_r}) - $signed({1'b0, head_r});
    if (diff_w > E_180) begin
      e_w = diff_w - E_360;
    end else if (diff_w < -E_180) begin
      e_w = diff_w + E_360;
    end else begin
      e_w = diff_w;
    end
    ae_w = e_w[ERR_W] ? -e_w : e_w;
  end

  // Elapsed times since turn start and settle window start
  assign elapsed_w   = time_r - turn_start_r;
  assign settle_el_w = time_r - win_start_r;
  assign settled_w   = near1_r && (settle_el_w >= TIME_W'(settle_r));

  // Status for the sequencer
  always_comb begin
    sts           = '0;
    sts.idle_hit  = finished_r;
    sts.tmo_hit   = elapsed_w >= TIME_W'(tmo_r);
    sts.cut_hit   = (ae_w < A_15) && !gain_cut_r;
    sts.brake_hit = near20_r;
  end

  // Integral update: accumulate and clamp near target, clear otherwise
  always_comb begin
    esum_sum = (ESUM_W+1)'(esum_r) + (ESUM_W+1)'(e_r);
    if (!near15_r) begin
      esum_nxt = '0;
    end else if (esum_sum > S_MAX) begin
      esum_nxt = ESUM_W'(S_MAX);
    end else if (esum_sum < -S_MAX) begin
      esum_nxt = ESUM_W'(-S_MAX);
    end else begin
      esum_nxt = ESUM_W'(esum_sum);
    end
  end

  assign de_w = DERR_W'(e_r) - DERR_W'(last_err_r);

  // Select operands for the shared unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctl.op_sel)
      OP_CUT: begin
        op_a = MUL_A_W'(active_r);
        op_b = MUL_B_W'(CUT_MULT);
      end
      OP_PROP: begin
        op_a = MUL_A_W'(active_r);
        op_b = MUL_B_W'(e_r);
      end
      OP_INTEG: begin
        op_a = MUL_A_W'(igain_r);
        op_b = MUL_B_W'(esum_r);
      end
      OP_DERIV: begin
        op_a = MUL_A_W'(dgain_r);
        op_b = MUL_B_W'(de_w);
      end
      OP_BRK_LO: begin
        op_a = MUL_A_W'(brake_r);
        op_b = MUL_B_W'(acc_q[BRK_SPLIT-1:0]);
      end
      OP_BRK_HI: begin
        op_a = MUL_A_W'(brake_r);
        op_b = brk_hi_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  hpt_mac u_mac (
    .clk   (clk),
    .en    (ctl.mac_en),
    .clr   (ctl.mac_clr),
    .sh_hi (ctl.mac_sh_hi),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc_q)
  );

  hpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Scale the sum to 1/256 percent: truncate magnitude, clamp, restore sign
  always_comb begin
    mag_w   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    shr_w   = near20_r ? (mag_w >> SHIFT_BRAKE) : (mag_w >> SHIFT_PLAIN);
    lim_w   = (shr_w > ACC_W'(DRIVE_LIMIT)) ? DRIVE_W'(DRIVE_LIMIT)
                                            : shr_w[DRIVE_W-1:0];
    drive_w = acc_q[ACC_W-1] ? -$signed(lim_w) : $signed(lim_w);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      pgain_r  <= GAIN_W'(65536);
      igain_r  <= '0;
      dgain_r  <= '0;
      brake_r  <= BRAKE_W'(77);
      tmo_r    <= MS_W'(3000);
      settle_r <= MS_W'(50);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TARGET:  target_r <= cfg_wdata[HEAD_W-1:0];
        CFG_PGAIN:   pgain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_IGAIN:   igain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_DGAIN:   dgain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_BRAKE:   brake_r  <= cfg_wdata[BRAKE_W-1:0];
        CFG_TIMEOUT: tmo_r    <= cfg_wdata[MS_W-1:0];
        CFG_SETTLE:  settle_r <= cfg_wdata[MS_W-1:0];
        default:     target_r <= target_r;
      endcase
    end
  end

  // Turn state: start, gain cut, integral, settle window and finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r       <= '0;
      last_err_r   <= '0;
      active_r     <= '0;
      gain_cut_r   <= 1'b0;
      turn_start_r <= '0;
      win_start_r  <= '0;
      finished_r   <= 1'b1;
      end_reason_r <= RSN_RUN;
    end else begin
      if (start) begin
        esum_r       <= '0;
        last_err_r   <= '0;
        active_r     <= pgain_r;
        gain_cut_r   <= 1'b0;
        turn_start_r <= in_tdata[HEAD_W+TIME_W-1:HEAD_W];
        win_start_r  <= in_tdata[HEAD_W+TIME_W-1:HEAD_W];
        finished_r   <= 1'b0;
        end_reason_r <= RSN_RUN;
      end
      if (ctl.eval && !finished_r && sts.tmo_hit) begin
        finished_r   <= 1'b1;
        end_reason_r <= RSN_TIMEOUT;
      end
      if (ctl.cut_wr) begin
        active_r   <= acc_q[CUT_SHIFT+GAIN_W-1:CUT_SHIFT];
        gain_cut_r <= 1'b1;
      end
      if (ctl.esum_wr) begin
        esum_r <= esum_nxt;
      end
      if (ctl.fin) begin
        if (settled_w) begin
          finished_r   <= 1'b1;
          end_reason_r <= RSN_SETTLED;
        end else begin
          last_err_r <= e_r;
          if (!near1_r) win_start_r <= time_r;
        end
      end
    end
  end

  // Item registers: capture sample, error and distance flags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      head_r <= in_tdata[HEAD_W-1:0];
      time_r <= in_tdata[HEAD_W+TIME_W-1:HEAD_W];
    end
    if (ctl.eval) begin
      e_r      <= e_w[ERR_W-1:0];
      near1_r  <= ae_w < A_1;
      near15_r <= ae_w < A_15;
      near20_r <= ae_w < A_20;
    end
    if (ctl.brk_save) begin
      brk_hi_r <= acc_q[BRK_SPLIT+MUL_B_W-1:BRK_SPLIT];
    end
  end

  // Result register: load on idle, timeout or the final step
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      out_drive_r  <= '0;
      out_done_r   <= 1'b1;
      out_reason_r <= finished_r ? end_reason_r : RSN_TIMEOUT;
    end else if (ctl.fin) begin
      if (settled_w) begin
        out_drive_r  <= '0;
        out_done_r   <= 1'b1;
        out_reason_r <= RSN_SETTLED;
      end else begin
        out_drive_r  <= drive_w;
        out_done_r   <= 1'b0;
        out_reason_r <= RSN_RUN;
      end
    end
  end

  assign in_tready  = ctl.in_ready;
  assign out_tvalid = ctl.out_valid;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = {out_reason_r, out_done_r};

  // Checks
  `HPT_ASSERT_IMP(a_drive_range, ctl.out_valid, (out_drive_r <= D_MAX) && (out_drive_r >= -D_MAX), "drive beyond limit")
  `HPT_ASSERT_IMP(a_done_zero, ctl.out_valid && out_done_r, out_drive_r == '0, "done with nonzero drive")
  `HPT_ASSERT_IMP(a_reason_done, ctl.out_valid && (out_reason_r != RSN_RUN), out_done_r, "reason without done")
  `HPT_ASSERT_IMP(a_one_item, ctl.in_ready, !ctl.out_valid, "ready while a result waits")
  `HPT_ASSERT_IMP(a_esum_range, 1'b1, (esum_r <= ESUM_W'(S_MAX)) && (esum_r >= ESUM_W'(-S_MAX)), "integral beyond clamp")
  `HPT_ASSERT_NEXT(a_cut_sticky, gain_cut_r && !start, gain_cut_r, "gain cut lost within a turn")

endmodule

`default_nettype wire
